@@ hw/rtl/ubd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ubd_pkg;

    localparam int CLOCK_W   = 27;
    localparam int BAUD_W    = 24;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_W     = 32;
    localparam int DEN_W     = BAUD_W + 2;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE = 1'd1;

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd16000000;
    localparam logic [NUM_W-1:0]   NUM_SCALE      = 32'd25;

    localparam int MANT_W = 12;
    localparam int FRAC_W = 4;
    localparam logic [MANT_W-1:0] MANT_MAX = 12'hFFF;
    localparam logic [FRAC_W-1:0] FRAC_MASK_BY8  = 4'h7;
    localparam logic [FRAC_W-1:0] FRAC_MASK_BY16 = 4'hF;

    // mantissa above MANT_MAX once the quotient reaches (MANT_MAX + 1) * 100
    localparam logic [NUM_W-1:0] SAT_LIMIT = 32'd409600;

    // quotient below SAT_LIMIT fits here
    localparam int QLO_W = 19;

    // divide by 100: x * ceil(2^26 / 100) >> 26, exact for x below 2^19
    localparam int                RECIP_SHIFT = 26;
    localparam int                RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_100  = 20'd671089;
    localparam int                PROD_W      = QLO_W + RECIP_W;

    localparam int               REM_W       = 7;
    localparam logic [REM_W-1:0] HUNDRED     = 7'd100;

    // fraction rounding: (rem * 16 + 50) fits 11 bits, divide by 100 via 1311 >> 17
    localparam int                  RND_W       = 11;
    localparam logic [RND_W-1:0]    RND_HALF    = 11'd50;
    localparam int                  FRECIP_W    = 11;
    localparam logic [FRECIP_W-1:0] FRECIP_100  = 11'd1311;
    localparam int                  FRECIP_SHIFT = 17;
    localparam int                  FPROD_W     = RND_W + FRECIP_W;

endpackage

`default_nettype wire

@@ hw/rtl/uart_baud_divisor_calc.sv @@
// Baud register word calculator for a fractional USART baud generator.
// Request channel: a baud rate on baud_rate is taken at each rising edge
// with start high and busy low. busy never rises, so a request may be
// given in every cycle.
// Result channel: done is high for one cycle with divisor_word and
// error_flag valid in that cycle. Results come out in request order,
// at most one per cycle.
// The receiver cannot stall; the pipeline never holds back.
// The pipeline is an entry stage, the restoring divider with one quotient
// bit per stage over 32 stages, two stages splitting the quotient by 100
// and one output stage that rounds the fraction.
// Configuration: cfg_valid with cfg_index and cfg_data writes clock_hz
// (index 0) or oversample_by_eight (index 1, bit 0); cfg_ready is always
// high. Write only while no request is in flight.
// Reset clears all pipeline valid bits, sets clock_hz to 16000000 and
// selects oversampling by 16. Baud zero gives word 0 with error_flag;
// a mantissa above 12 bits gives a saturated word with error_flag.
`timescale 1ns / 1ps
`default_nettype none

module uart_baud_divisor_calc
    import ubd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [BAUD_W-1:0]    baud_rate,
    output      logic                 busy,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CLOCK_W-1:0]   cfg_data,
    output      logic                 done,
    output      logic [WORD_W-1:0]    divisor_word,
    output      logic                 error_flag
);

    logic [CLOCK_W-1:0] clock_hz_reg;
    logic               by8_reg;

    logic               vld_reg  [0:DIV_STEPS];
    logic               zero_reg [0:DIV_STEPS];
    logic               mode_reg [0:DIV_STEPS];
    logic [DEN_W-1:0]   den_reg  [0:DIV_STEPS];
    logic [DEN_W-1:0]   rem_reg  [0:DIV_STEPS];
    logic [NUM_W-1:0]   w_reg    [0:DIV_STEPS];

    logic [DEN_W-1:0]   rem_next [1:DIV_STEPS];
    logic [NUM_W-1:0]   w_next   [1:DIV_STEPS];
    logic [DEN_W:0]     trial    [1:DIV_STEPS];
    logic [DEN_W:0]     diff     [1:DIV_STEPS];
    logic               ge       [1:DIV_STEPS];

    logic               s1_vld_reg;
    logic               s1_zero_reg;
    logic               s1_mode_reg;
    logic               s1_sat_reg;
    logic [QLO_W-1:0]   s1_x_reg;
    logic [PROD_W-1:0]  s1_prod_reg;

    logic               s2_vld_reg;
    logic               s2_zero_reg;
    logic               s2_mode_reg;
    logic               s2_sat_reg;
    logic [MANT_W-1:0]  s2_mant_reg;
    logic [REM_W-1:0]   s2_rem_reg;

    logic               done_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               err_reg;

    logic [MANT_W-1:0]  mant_next;
    logic [QLO_W-1:0]   rem_wide;
    logic [RND_W-1:0]   rnd;
    logic [FPROD_W-1:0] fprod;
    logic [FRAC_W-1:0]  frac_mask;
    logic [FRAC_W-1:0]  frac;
    logic [WORD_W-1:0]  word_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            by8_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CLOCK_HZ:   clock_hz_reg <= cfg_data;
                CFG_OVERSAMPLE: by8_reg      <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // divider stages: one quotient bit each, shifted into the numerator word
    always_comb
    begin
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            trial[j]    = {rem_reg[j-1], w_reg[j-1][NUM_W-1]};
            diff[j]     = trial[j] - {1'b0, den_reg[j-1]};
            ge[j]       = trial[j] >= {1'b0, den_reg[j-1]};
            rem_next[j] = ge[j] ? diff[j][DEN_W-1:0] : trial[j][DEN_W-1:0];
            w_next[j]   = {w_reg[j-1][NUM_W-2:0], ge[j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= baud_rate == '0;
        mode_reg[0] <= by8_reg;
        den_reg[0]  <= by8_reg ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};
        rem_reg[0]  <= '0;
        w_reg[0]    <= NUM_W'(clock_hz_reg) * NUM_SCALE;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            zero_reg[j] <= zero_reg[j-1];
            mode_reg[j] <= mode_reg[j-1];
            den_reg[j]  <= den_reg[j-1];
            rem_reg[j]  <= rem_next[j];
            w_reg[j]    <= w_next[j];
        end
    end

    // split the quotient by 100
    always_comb
    begin
        mant_next = s1_prod_reg[RECIP_SHIFT +: MANT_W];
        rem_wide  = s1_x_reg - (QLO_W'(mant_next) * QLO_W'(HUNDRED));
    end

    // round the fraction
    always_comb
    begin
        frac_mask = s2_mode_reg ? FRAC_MASK_BY8 : FRAC_MASK_BY16;
        rnd       = s2_mode_reg ? {1'b0, s2_rem_reg, 3'b000} : {s2_rem_reg, 4'b0000};
        rnd       = rnd + RND_HALF;
        fprod     = FPROD_W'(rnd) * FPROD_W'(FRECIP_100);
        frac      = fprod[FRECIP_SHIFT +: FRAC_W] & frac_mask;
        if (s2_zero_reg)
        begin
            word_next = '0;
        end
        else if (s2_sat_reg)
        begin
            word_next = {MANT_MAX, frac_mask};
        end
        else
        begin
            word_next = {s2_mant_reg, frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld_reg[DIV_STEPS];
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg <= zero_reg[DIV_STEPS];
        s1_mode_reg <= mode_reg[DIV_STEPS];
        s1_sat_reg  <= w_reg[DIV_STEPS] >= SAT_LIMIT;
        s1_x_reg    <= w_reg[DIV_STEPS][QLO_W-1:0];
        s1_prod_reg <= PROD_W'(w_reg[DIV_STEPS][QLO_W-1:0]) * PROD_W'(RECIP_100);

        s2_zero_reg <= s1_zero_reg;
        s2_mode_reg <= s1_mode_reg;
        s2_sat_reg  <= s1_sat_reg;
        s2_mant_reg <= mant_next;
        s2_rem_reg  <= rem_wide[REM_W-1:0];

        word_reg    <= word_next;
        err_reg     <= s2_zero_reg | s2_sat_reg;
    end

    assign done         = done_reg;
    assign divisor_word = word_reg;
    assign error_flag   = err_reg;

endmodule

`default_nettype wire
